// ===== design/rwpc_pkg.sv =====
package rwpc_pkg;

    // ring of event times
    localparam int RING_DEPTH = 1024;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 12;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int STATUS_W = 4;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int WIN_W    = 17;

    // stream widths, padded to whole bytes
    localparam int IN_FIELDS_W  = DAY_W + MONTH_W + YEAR_W + HOUR_W + MINUTE_W + SECOND_W
                                  + STATUS_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 + 4 * COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // shifted year width: year plus the 400 year offset
    localparam int YY_W = 13;

    localparam logic [WIN_W-1:0]    WINDOW_RESET  = 17'd60;
    localparam logic [STATUS_W-1:0] STATUS_SERVER = 4'd5;
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = 32'hFFFF_FFFF;

    // date conversion constants
    localparam logic [16:0]       RECIP_100    = 17'd5243;   // x/100 = x*5243 >> 19
    localparam int                RECIP_SHIFT  = 19;
    localparam logic [16:0]       DAYS_PER_YR  = 17'd365;
    localparam logic [16:0]       SECS_PER_DAY = 17'd86400;
    localparam logic [16:0]       SECS_PER_HR  = 17'd3600;
    localparam logic [16:0]       SECS_PER_MIN = 17'd60;
    // day count of the shifted epoch plus the one from a 1-based day
    localparam logic [TIME_W-1:0] DAYS_BIAS    = 32'd865566;

    // shifted year: year + 400, less one when the march-based year starts earlier,
    // plus one when the month runs into the following year past february
    function automatic logic [YY_W-1:0] shifted_year(input logic [YEAR_W-1:0] year,
                                                     input logic [MONTH_W-1:0] month);
        logic [YY_W-1:0] base;
        base = {1'b0, year} + 13'd400;
        case (month)
            4'd0, 4'd1, 4'd2: shifted_year = base - 13'd1;
            4'd15:            shifted_year = base + 13'd1;
            default:          shifted_year = base;
        endcase
    endfunction

    // days from march 1 to the first of the (normalized) month
    function automatic logic [8:0] month_base(input logic [MONTH_W-1:0] month);
        case (month)
            4'd0:    month_base = 9'd275;
            4'd1:    month_base = 9'd306;
            4'd2:    month_base = 9'd337;
            4'd3:    month_base = 9'd0;
            4'd4:    month_base = 9'd31;
            4'd5:    month_base = 9'd61;
            4'd6:    month_base = 9'd92;
            4'd7:    month_base = 9'd122;
            4'd8:    month_base = 9'd153;
            4'd9:    month_base = 9'd184;
            4'd10:   month_base = 9'd214;
            4'd11:   month_base = 9'd245;
            4'd12:   month_base = 9'd275;
            4'd13:   month_base = 9'd306;
            4'd14:   month_base = 9'd337;
            default: month_base = 9'd0;
        endcase
    endfunction

    // ring slot increment with wrap
    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
        if (s == SLOT_W'(RING_DEPTH - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = s + 1'b1;
        end
    endfunction

endpackage

// ===== design/request_window_peak_counter_core.sv =====
// Sliding-window peak counter for request events. Each input request carries a
// calendar date, a time of day and the first digit of its status code; the block
// turns the date into UTC seconds since 1970 (out-of-range fields carry over as a
// normalizing calendar conversion does, result wrapping at 32 bits), stores it in
// a ring of RING_DEPTH event times and returns one result per request: the
// server-error flag, the saturating count of status-5 requests, the peak window
// count with the indices of its first and last request, and a sticky overflow
// flag that rises when the window holds more requests than the ring. The block
// takes a new request only when idle, and a result waits while the previous one
// is held by m_axis_tready. Five passes through the single shared multiply-add
// unit do the date conversion; each window start step is one read of the ring
// memory through its registered read port. window_seconds is to be written
// through cfg_wr_en/cfg_wr_data by the user only while no request is in flight;
// the block itself does not enforce this. A value of 0 acts as 1. After reset
// the window is 60 seconds.
module request_window_peak_counter_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // day_of_month, month_number, year_number, hour_of_day, minute_of_hour,
    // second_of_minute, status_class, zero pad
    input  logic [rwpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // is_server_error, error_total, peak_count, peak_first, peak_last,
    // window_overflow, zero pad
    output logic [rwpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             cfg_wr_en,
    input  logic [rwpc_pkg::WIN_W-1:0]       cfg_wr_data
);
    import rwpc_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CONV1  = 4'd1;
    localparam logic [3:0] ST_CONV2  = 4'd2;
    localparam logic [3:0] ST_CONV3  = 4'd3;
    localparam logic [3:0] ST_CONV4  = 4'd4;
    localparam logic [3:0] ST_CONV5  = 4'd5;
    localparam logic [3:0] ST_EVAL   = 4'd6;
    localparam logic [3:0] ST_READ   = 4'd7;
    localparam logic [3:0] ST_CHECK  = 4'd8;
    localparam logic [3:0] ST_FINISH = 4'd9;

    logic [3:0]             state_reg, state_next;

    // captured request fields
    logic [DAY_W-1:0]       day_reg;
    logic [MONTH_W-1:0]     month_reg;
    logic [YEAR_W-1:0]      year_reg;
    logic [HOUR_W-1:0]      hour_reg;
    logic [MINUTE_W-1:0]    minute_reg;
    logic [SECOND_W-1:0]    second_reg;
    logic [STATUS_W-1:0]    status_reg;

    // accumulator of the shared unit, holds the event time once converted
    logic [TIME_W-1:0]      acc_reg;

    logic [COUNT_W-1:0]     event_index_reg, event_index_next;
    logic [COUNT_W-1:0]     window_start_reg, window_start_next;
    logic [SLOT_W-1:0]      head_slot_reg, head_slot_next;
    logic [SLOT_W-1:0]      start_slot_reg, start_slot_next;
    logic [COUNT_W-1:0]     best_count_reg, best_count_next;
    logic [COUNT_W-1:0]     best_first_reg, best_first_next;
    logic [COUNT_W-1:0]     best_last_reg, best_last_next;
    logic [COUNT_W-1:0]     error_count_reg, error_count_next;
    logic                   overflow_reg, overflow_next;
    logic [WIN_W-1:0]       window_seconds_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    // ring memory
    logic [TIME_W-1:0]      ring_mem [RING_DEPTH];
    logic [TIME_W-1:0]      ring_rd_reg;
    logic                   ring_we;

    // shared multiply-add unit
    logic [TIME_W-1:0]      mul_a;
    logic [16:0]            mul_b;
    logic [TIME_W-1:0]      add_c;
    logic [TIME_W+16:0]     mac_prod;
    logic [TIME_W-1:0]      mac_sum;

    logic [YY_W-1:0]        yy;
    logic [5:0]             q100;
    logic [TIME_W-1:0]      days_addend;
    logic [COUNT_W-1:0]     span;
    logic [TIME_W-1:0]      t_cmp;
    logic [TIME_W-1:0]      t_diff;
    logic [WIN_W-1:0]       w_eff;
    logic                   reached;
    logic                   is_err;
    logic                   s_accept;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // calendar terms of the date conversion
    assign yy          = shifted_year(year_reg, month_reg);
    assign q100        = acc_reg[RECIP_SHIFT+5:RECIP_SHIFT];
    assign days_addend = 32'(yy[YY_W-1:2]) - 32'(q100) + 32'(q100[5:2])
                         + 32'(month_base(month_reg)) + 32'(day_reg) - DAYS_BIAS;

    // operand select for the shared unit
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        add_c = '0;
        unique case (state_reg)
            ST_CONV1:
            begin
                mul_a = 32'(yy);
                mul_b = RECIP_100;
            end
            ST_CONV2:
            begin
                mul_a = 32'(yy);
                mul_b = DAYS_PER_YR;
                add_c = days_addend;
            end
            ST_CONV3:
            begin
                mul_a = acc_reg;
                mul_b = SECS_PER_DAY;
                add_c = 32'(second_reg);
            end
            ST_CONV4:
            begin
                mul_a = 32'(hour_reg);
                mul_b = SECS_PER_HR;
                add_c = acc_reg;
            end
            ST_CONV5:
            begin
                mul_a = 32'(minute_reg);
                mul_b = SECS_PER_MIN;
                add_c = acc_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mac_prod = mul_a * mul_b;
    assign mac_sum  = mac_prod[TIME_W-1:0] + add_c;

    // window test: newest minus start, as signed, at least the window length
    assign w_eff   = (window_seconds_reg == '0) ? WIN_W'(1) : window_seconds_reg;
    assign span    = event_index_reg - window_start_reg;
    assign t_cmp   = (state_reg == ST_EVAL && span == '0) ? acc_reg : ring_rd_reg;
    assign t_diff  = acc_reg - t_cmp;
    assign reached = !t_diff[TIME_W-1] && (t_diff >= 32'(w_eff));
    assign is_err  = (status_reg == STATUS_SERVER);
    assign ring_we = (state_reg == ST_EVAL);

    // sequencer and window bookkeeping
    always_comb
    begin
        state_next        = state_reg;
        event_index_next  = event_index_reg;
        window_start_next = window_start_reg;
        head_slot_next    = head_slot_reg;
        start_slot_next   = start_slot_reg;
        best_count_next   = best_count_reg;
        best_first_next   = best_first_reg;
        best_last_next    = best_last_reg;
        error_count_next  = error_count_reg;
        overflow_next     = overflow_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_CONV1;
                end
            end
            ST_CONV1: state_next = ST_CONV2;
            ST_CONV2: state_next = ST_CONV3;
            ST_CONV3: state_next = ST_CONV4;
            ST_CONV4: state_next = ST_CONV5;
            ST_CONV5: state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (reached)
                begin
                    if (best_count_reg < span)
                    begin
                        best_count_next = span;
                        best_first_next = window_start_reg;
                        best_last_next  = event_index_reg - 1'b1;
                    end
                    window_start_next = window_start_reg + 1'b1;
                    start_slot_next   = slot_next(start_slot_reg);
                    state_next        = ST_READ;
                end
                else
                begin
                    if (span >= 32'(RING_DEPTH))
                    begin
                        overflow_next     = 1'b1;
                        window_start_next = window_start_reg + 1'b1;
                        start_slot_next   = slot_next(start_slot_reg);
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_READ: state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (window_start_reg != event_index_reg && reached)
                begin
                    window_start_next = window_start_reg + 1'b1;
                    start_slot_next   = slot_next(start_slot_reg);
                    state_next        = ST_READ;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    if (is_err && error_count_reg != COUNT_MAX)
                    begin
                        error_count_next = error_count_reg + 1'b1;
                    end
                    event_index_next = event_index_reg + 1'b1;
                    head_slot_next   = slot_next(head_slot_reg);
                    m_valid_next     = 1'b1;
                    m_data_next      = OUT_TDATA_W'({overflow_reg, best_last_reg,
                                                     best_first_reg, best_count_reg,
                                                     error_count_next, is_err});
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            event_index_reg    <= '0;
            window_start_reg   <= '0;
            head_slot_reg      <= '0;
            start_slot_reg     <= '0;
            best_count_reg     <= '0;
            best_first_reg     <= '0;
            best_last_reg      <= '0;
            error_count_reg    <= '0;
            overflow_reg       <= 1'b0;
            window_seconds_reg <= WINDOW_RESET;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            event_index_reg  <= event_index_next;
            window_start_reg <= window_start_next;
            head_slot_reg    <= head_slot_next;
            start_slot_reg   <= start_slot_next;
            best_count_reg   <= best_count_next;
            best_first_reg   <= best_first_next;
            best_last_reg    <= best_last_next;
            error_count_reg  <= error_count_next;
            overflow_reg     <= overflow_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_wr_en)
            begin
                window_seconds_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            day_reg    <= s_axis_tdata[4:0];
            month_reg  <= s_axis_tdata[8:5];
            year_reg   <= s_axis_tdata[20:9];
            hour_reg   <= s_axis_tdata[25:21];
            minute_reg <= s_axis_tdata[31:26];
            second_reg <= s_axis_tdata[37:32];
            status_reg <= s_axis_tdata[41:38];
        end
        if (state_reg == ST_CONV1 || state_reg == ST_CONV2 || state_reg == ST_CONV3
            || state_reg == ST_CONV4 || state_reg == ST_CONV5)
        begin
            acc_reg <= mac_sum;
        end
        m_data_reg <= m_data_next;
    end

    // ring of event times: one write port at the head, registered read at the start
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[head_slot_reg] <= acc_reg;
        end
        ring_rd_reg <= ring_mem[start_slot_reg];
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rwpc_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SECS_IN_DAY    = 86400;

    // one request, day_of_month in the lowest bits
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } request_t;

    // one result, is_server_error in the lowest bit
    typedef struct packed {
        logic               overflow;
        logic [COUNT_W-1:0] peak_last;
        logic [COUNT_W-1:0] peak_first;
        logic [COUNT_W-1:0] peak_count;
        logic [COUNT_W-1:0] error_total;
        logic               server_error;
    } summary_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_wr_en     = 1'b0;
    logic [WIN_W-1:0]       cfg_wr_data   = WINDOW_RESET;

    // predictor state
    logic [TIME_W-1:0]  event_time_mem [RING_DEPTH];
    logic [COUNT_W-1:0] seen_requests  = '0;
    logic [COUNT_W-1:0] oldest_request = '0;
    logic [COUNT_W-1:0] top_count      = '0;
    logic [COUNT_W-1:0] top_first      = '0;
    logic [COUNT_W-1:0] top_last       = '0;
    logic [COUNT_W-1:0] error_tally    = '0;
    logic               ring_overflowed = 1'b0;
    logic [WIN_W-1:0]   window_len     = WINDOW_RESET;
    int unsigned        head_slot      = 0;
    int unsigned        oldest_slot    = 0;

    summary_t    pending_summaries [$];
    int unsigned failures    = 0;
    int unsigned idle_cycles = 0;
    int          rx_hold     = 0;
    bit          tx_calm     = 1'b0;
    bit          rx_calm     = 1'b0;

    // calendar used to build well-formed request sequences
    int cal_year  = 2000;
    int cal_month = 1;
    int cal_day   = 1;
    int cal_sod   = 0;

    always #HALF_PERIOD clk = ~clk;

    request_window_peak_counter_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // utc seconds since 1970 with calendar normalization, wrapped to 32 bits
    function automatic logic [TIME_W-1:0] epoch_seconds(request_t r);
        longint day_n, mon, yr, m, yy, era, yoe, mp, doe, days, secs;
        day_n = r.day;
        mon   = r.month;
        mon   = mon - 1;
        yr    = r.year;
        if (mon < 0)
        begin
            mon = mon + 12;
            yr  = yr - 1;
        end
        yr   = yr + mon / 12;
        mon  = mon % 12;
        m    = mon + 1;
        yy   = yr - ((m <= 2) ? 1 : 0) + 400;
        era  = yy / 400;
        yoe  = yy - era * 400;
        mp   = (m > 2) ? m - 3 : m + 9;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + (153 * mp + 2) / 5;
        days = (era - 1) * 146097 + doe - 719468 + day_n - 1;
        secs = days * SECS_IN_DAY + longint'(r.hour) * 3600 + longint'(r.minute) * 60
               + longint'(r.second);
        return TIME_W'(secs);
    endfunction

    // newer - older, read as signed, has reached the window length
    function automatic bit window_reached(logic [TIME_W-1:0] newer, logic [TIME_W-1:0] older,
                                          logic [COUNT_W-1:0] len);
        logic [TIME_W-1:0] diff;
        diff = newer - older;
        return !diff[TIME_W-1] && (diff >= len);
    endfunction

    // advance the window state by one request and return the result it causes
    function automatic summary_t predict_summary(request_t r);
        logic [TIME_W-1:0]  t_new;
        logic [TIME_W-1:0]  t_oldest;
        logic [COUNT_W-1:0] len;
        logic [COUNT_W-1:0] span;
        summary_t           s;
        t_new    = epoch_seconds(r);
        len      = (window_len == '0) ? COUNT_W'(1) : COUNT_W'(window_len);
        span     = seen_requests - oldest_request;
        t_oldest = (span == '0) ? t_new : event_time_mem[oldest_slot];
        event_time_mem[head_slot] = t_new;

        if (window_reached(t_new, t_oldest, len))
        begin
            if (top_count < span)
            begin
                top_count = span;
                top_first = oldest_request;
                top_last  = seen_requests - 1;
            end
            oldest_request = oldest_request + 1;
            oldest_slot    = (oldest_slot + 1) % RING_DEPTH;
            while (oldest_request != seen_requests &&
                   window_reached(t_new, event_time_mem[oldest_slot], len))
            begin
                oldest_request = oldest_request + 1;
                oldest_slot    = (oldest_slot + 1) % RING_DEPTH;
            end
        end
        else if (span >= RING_DEPTH)
        begin
            // window holds more than the ring: drop the oldest request
            ring_overflowed = 1'b1;
            oldest_request  = oldest_request + 1;
            oldest_slot     = (oldest_slot + 1) % RING_DEPTH;
        end

        if (r.status == STATUS_SERVER && error_tally != COUNT_MAX)
        begin
            error_tally = error_tally + 1;
        end
        seen_requests = seen_requests + 1;
        head_slot     = (head_slot + 1) % RING_DEPTH;

        s.server_error = (r.status == STATUS_SERVER);
        s.error_total  = error_tally;
        s.peak_count   = top_count;
        s.peak_first   = top_first;
        s.peak_last    = top_last;
        s.overflow     = ring_overflowed;
        return s;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [STATUS_W-1:0] pick_status();
        return ($urandom_range(0, 3) == 0) ? STATUS_SERVER : STATUS_W'($urandom_range(0, 15));
    endfunction

    function automatic request_t make_request(int d, int mo, int y, int h, int mi, int s,
                                              logic [STATUS_W-1:0] st);
        request_t r;
        r.day    = DAY_W'(d);
        r.month  = MONTH_W'(mo);
        r.year   = YEAR_W'(y);
        r.hour   = HOUR_W'(h);
        r.minute = MINUTE_W'(mi);
        r.second = SECOND_W'(s);
        r.status = st;
        return r;
    endfunction

    function automatic request_t clock_request(int sod, logic [STATUS_W-1:0] st);
        return make_request(cal_day, cal_month, cal_year, sod / 3600, (sod / 60) % 60, sod % 60,
                            st);
    endfunction

    function automatic void set_clock(int y, int mo, int d, int sod);
        cal_year  = y;
        cal_month = mo;
        cal_day   = d;
        cal_sod   = sod;
    endfunction

    // move the calendar forward, keeping every field in its normal range
    function automatic void advance_clock(int step);
        cal_sod = cal_sod + step;
        while (cal_sod >= SECS_IN_DAY)
        begin
            cal_sod = cal_sod - SECS_IN_DAY;
            cal_day = cal_day + 1;
            if (cal_day > 28)
            begin
                cal_day   = 1;
                cal_month = cal_month + 1;
                if (cal_month > 12)
                begin
                    cal_month = 1;
                    cal_year  = cal_year + 1;
                end
            end
        end
    endfunction

    // present one request after a random gap and wait for it to be taken
    task automatic send_request(request_t r);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(r);
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_summaries.push_back(predict_summary(r));
    endtask

    task automatic send_clock_request();
        send_request(clock_request(cal_sod, pick_status()));
    endtask

    // hold off until every result is back and the block has gone quiet
    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        wait (pending_summaries.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(logic [WIN_W-1:0] value);
        drain_requests();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        window_len = value;
    endtask

    task automatic compare_field(string name, logic [COUNT_W-1:0] want,
                                 logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic check_summary(summary_t got);
        summary_t want;
        if (pending_summaries.size() == 0)
        begin
            $error("result with no request pending");
            failures++;
        end
        else
        begin
            want = pending_summaries.pop_front();
            compare_field("is_server_error", COUNT_W'(want.server_error),
                          COUNT_W'(got.server_error));
            compare_field("error_total", want.error_total, got.error_total);
            compare_field("peak_count", want.peak_count, got.peak_count);
            compare_field("peak_first", want.peak_first, got.peak_first);
            compare_field("peak_last", want.peak_last, got.peak_last);
            compare_field("window_overflow", COUNT_W'(want.overflow), COUNT_W'(got.overflow));
        end
    endtask

    // result side: check each accepted result, then stall at random
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            check_summary(summary_t'(m_axis_tdata[OUT_FIELDS_W-1:0]));
        end
        if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 4) == 0)
            begin
                rx_hold = pick_gap();
            end
        end
    end

    // watchdog on cycles where neither side moves
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // field extremes, calendar carries and a first window under the reset length
    task automatic test_field_extremes();
        int i;
        send_request(make_request(1, 1, 1970, 0, 0, 0, 4'd0));
        send_request(make_request(31, 12, 2105, 23, 59, 60, STATUS_SERVER));
        send_request(make_request(0, 1, 1970, 0, 0, 0, STATUS_SERVER));
        send_request(make_request(31, 15, 4095, 31, 63, 63, 4'd15));
        send_request(make_request(0, 0, 0, 0, 0, 0, 4'd0));
        send_request(make_request(1, 13, 2000, 12, 30, 30, 4'd9));
        send_request(make_request(29, 2, 2000, 0, 0, 0, STATUS_SERVER));
        send_request(make_request(29, 2, 2100, 0, 0, 0, 4'd4));
        set_clock(2020, 6, 15, 3600);
        for (i = 0; i < 4; i++)
        begin
            send_clock_request();
            advance_clock(20);
        end
        advance_clock(61);
        send_clock_request();
    endtask

    // smallest, zero and one-day window lengths
    task automatic test_window_extremes();
        int i;
        write_window(WIN_W'(1));
        set_clock(2001, 3, 1, 0);
        for (i = 0; i < 3; i++)
        begin
            send_clock_request();
        end
        advance_clock(1);
        send_clock_request();

        // zero length acts as one second
        write_window('0);
        send_clock_request();
        send_clock_request();
        advance_clock(1);
        send_clock_request();
        advance_clock(2);
        send_clock_request();

        write_window(WIN_W'(SECS_IN_DAY));
        for (i = 0; i < 3; i++)
        begin
            advance_clock(3600);
            send_clock_request();
        end
        advance_clock(SECS_IN_DAY);
        send_clock_request();
    endtask

    // phases of time-ordered traffic with some late requests and noise
    task automatic test_random_traffic(int total);
        int sent;
        int phase_len;
        int w;
        int k;
        int back;
        logic [63:0] raw;
        sent = 0;
        while (sent < total)
        begin
            k = $urandom_range(0, 9);
            if (k == 0)
            begin
                write_window(WIN_W'(SECS_IN_DAY));
            end
            else if (k == 1)
            begin
                write_window(WIN_W'($urandom_range(1, 2 ** WIN_W - 1)));
            end
            else
            begin
                write_window(WIN_W'($urandom_range(1, 40)));
            end
            w = (window_len == '0) ? 1 : int'(window_len);
            tx_calm   = ($urandom_range(0, 3) == 0);
            rx_calm   = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 60);
            set_clock($urandom_range(1970, 2100), $urandom_range(1, 12), $urandom_range(1, 28),
                      $urandom_range(0, SECS_IN_DAY - 1));
            repeat (phase_len)
            begin
                k = $urandom_range(0, 99);
                if (k < 80)
                begin
                    k = $urandom_range(0, 9);
                    if (k < 6)
                    begin
                        advance_clock($urandom_range(0, w / 4));
                    end
                    else if (k < 9)
                    begin
                        advance_clock($urandom_range(w / 4, w));
                    end
                    else
                    begin
                        advance_clock($urandom_range(w, 3 * w));
                    end
                    send_clock_request();
                end
                else if (k < 90)
                begin
                    // request stamped earlier than the current time
                    back = cal_sod - int'($urandom_range(1, 2 * w));
                    send_request(clock_request((back < 0) ? 0 : back, pick_status()));
                end
                else
                begin
                    raw = {$urandom, $urandom};
                    send_request(request_t'(raw[IN_FIELDS_W-1:0]));
                end
                sent++;
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_window_extremes();
        test_random_traffic(375);
        drain_requests();

        if (failures == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/rwpc_pkg.sv
design/request_window_peak_counter_core.sv
tb/tb.sv
